@@ rtl/core/cosl_pkg.sv @@
// Shared constants for the count ordered search list.
package cosl_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_W     = 8;
    localparam int CNT_W     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int FILL_W    = IDX_W + 1;
    localparam int SUM_W     = 32;

    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

endpackage

@@ rtl/core/count_ordered_search_list.sv @@
// Self-organizing key list ordered by access count, with one compare unit under a sequencer.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------------------------
//  input    | in        | i_in_valid / o_in_stall   | i_key
//  output   | out       | o_out_valid / i_out_stall | o_found, o_final_position,
//           |           |                           | o_access_count, o_list_size,
//           |           |                           | o_compare_total, o_dropped
//
// One word passes through the sequencer states in order: the key is latched in idle, the search
// compares from the front until a hit or the end of the fill (an empty list skips the search),
// a hit entry then moves toward the front past each predecessor with a lower count, a miss is
// appended at the tail or dropped on a full list, and the output register is loaded.
// The single key compare and the single registered read port of the entry store are walked
// one index per cycle.
// Reset is synchronous and active low; it empties the list and clears the running total.
// A result waiting under i_out_stall does not block the next input word, but the sequencer
// holds in its final state until the output register is free.
module count_ordered_search_list (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [cosl_pkg::KEY_W-1:0]  i_key,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [cosl_pkg::IDX_W-1:0]  o_final_position,
    output logic [cosl_pkg::CNT_W-1:0]  o_access_count,
    output logic [cosl_pkg::FILL_W-1:0] o_list_size,
    output logic [cosl_pkg::SUM_W-1:0]  o_compare_total,
    output logic                        o_dropped
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_BUBBLE = 3'd2;
    localparam logic [2:0] ST_MISS   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    // Entry store: one read address and one write address per cycle.
    logic [cosl_pkg::KEY_W-1:0] r_keys   [cosl_pkg::DEPTH];
    logic [cosl_pkg::CNT_W-1:0] r_counts [cosl_pkg::DEPTH];

    logic [2:0]                  r_state, n_state;
    logic [cosl_pkg::KEY_W-1:0]  r_key, n_key;
    logic [cosl_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [cosl_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [cosl_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [cosl_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic                        r_hit, n_hit;
    logic                        r_drop, n_drop;

    logic                        r_out_valid, n_out_valid;
    logic                        r_o_found, n_o_found;
    logic [cosl_pkg::IDX_W-1:0]  r_o_pos, n_o_pos;
    logic [cosl_pkg::CNT_W-1:0]  r_o_cnt, n_o_cnt;
    logic [cosl_pkg::FILL_W-1:0] r_o_size, n_o_size;
    logic [cosl_pkg::SUM_W-1:0]  r_o_total, n_o_total;
    logic                        r_o_drop, n_o_drop;

    logic [cosl_pkg::IDX_W-1:0]  rd_addr;
    logic [cosl_pkg::KEY_W-1:0]  r_rd_key;
    logic [cosl_pkg::CNT_W-1:0]  r_rd_cnt;
    logic [cosl_pkg::CNT_W-1:0]  inc_cnt;
    logic                        wr_en;
    logic [cosl_pkg::IDX_W-1:0]  wr_addr;
    logic [cosl_pkg::KEY_W-1:0]  wr_key;
    logic [cosl_pkg::CNT_W-1:0]  wr_cnt;

    // The read address follows the next state, so the registered read data always belongs to
    // the current index; while moving an entry forward it is the slot ahead of the entry.
    assign rd_addr = (n_state == ST_BUBBLE) ? (n_idx - 1'b1) : n_idx;
    assign inc_cnt = (r_rd_cnt == cosl_pkg::CNT_MAX) ? r_rd_cnt : (r_rd_cnt + 1'b1);

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_hit       = r_hit;
        n_drop      = r_drop;
        n_out_valid = r_out_valid;
        n_o_found   = r_o_found;
        n_o_pos     = r_o_pos;
        n_o_cnt     = r_o_cnt;
        n_o_size    = r_o_size;
        n_o_total   = r_o_total;
        n_o_drop    = r_o_drop;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_key      = r_key;
        wr_cnt      = r_cnt;

        // The downstream side takes the waiting result.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_key   = i_key;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_drop  = 1'b0;
                    n_state = (r_fill == '0) ? ST_MISS : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (r_rd_key == r_key) begin
                    n_cnt   = inc_cnt;
                    n_hit   = 1'b1;
                    n_sum   = r_sum + cosl_pkg::SUM_W'(r_idx) + 1'b1;
                    n_state = ST_BUBBLE;
                end else if (({1'b0, r_idx} + 1'b1) == r_fill) begin
                    n_state = ST_MISS;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_BUBBLE: begin
                // Pass a predecessor only when its count is strictly lower.
                if ((r_idx != '0) && (r_rd_cnt < r_cnt)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_key  = r_rd_key;
                    wr_cnt  = r_rd_cnt;
                    n_idx   = r_idx - 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_key  = r_key;
                    wr_cnt  = r_cnt;
                    n_state = ST_RESULT;
                end
            end
            ST_MISS: begin
                n_cnt = '0;
                n_sum = r_sum + ((r_fill == '0) ? cosl_pkg::SUM_W'(1)
                                                : cosl_pkg::SUM_W'(r_fill));
                if (r_fill == cosl_pkg::FILL_FULL) begin
                    n_drop = 1'b1;
                    n_idx  = '0;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_fill[cosl_pkg::IDX_W-1:0];
                    wr_key  = r_key;
                    wr_cnt  = '0;
                    n_idx   = r_fill[cosl_pkg::IDX_W-1:0];
                    n_fill  = r_fill + 1'b1;
                end
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_found   = r_hit;
                    n_o_pos     = r_idx;
                    n_o_cnt     = r_cnt;
                    n_o_size    = r_fill;
                    n_o_total   = r_sum;
                    n_o_drop    = r_drop;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_hit     <= n_hit;
        r_drop    <= n_drop;
        r_o_found <= n_o_found;
        r_o_pos   <= n_o_pos;
        r_o_cnt   <= n_o_cnt;
        r_o_size  <= n_o_size;
        r_o_total <= n_o_total;
        r_o_drop  <= n_o_drop;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_keys[wr_addr]   <= wr_key;
            r_counts[wr_addr] <= wr_cnt;
        end
        r_rd_key <= r_keys[rd_addr];
        r_rd_cnt <= r_counts[rd_addr];
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_found          = r_o_found;
    assign o_final_position = r_o_pos;
    assign o_access_count   = r_o_cnt;
    assign o_list_size      = r_o_size;
    assign o_compare_total  = r_o_total;
    assign o_dropped        = r_o_drop;

endmodule

@@ rtl/core/cosl_checker.sv @@
// Port-level checks for the count ordered search list, bound to the top level.
module cosl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_stall,
    input logic                        i_found,
    input logic [cosl_pkg::IDX_W-1:0]  i_final_position,
    input logic [cosl_pkg::CNT_W-1:0]  i_access_count,
    input logic [cosl_pkg::FILL_W-1:0] i_list_size,
    input logic                        i_dropped
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> i_out_valid)
        else $error("result word withdrawn while stalled");

    // A drop only happens on a full list and never together with a hit.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_dropped) |->
            (!i_found && (i_list_size == cosl_pkg::FILL_FULL)
             && (i_final_position == '0) && (i_access_count == '0)))
        else $error("drop reported with inconsistent fields");

    // A stored miss lands at the tail with a zero count.
    a_miss_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found && !i_dropped) |->
            ((i_access_count == '0)
             && ({1'b0, i_final_position} + 1'b1 == i_list_size)))
        else $error("inserted key not at the tail");

    // A hit always lies inside the held part of the list.
    a_hit_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_found) |->
            (({1'b0, i_final_position} < i_list_size) && (i_access_count != '0)))
        else $error("hit position outside the list");

endmodule

bind count_ordered_search_list cosl_checker u_cosl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .i_found          (o_found),
    .i_final_position (o_final_position),
    .i_access_count   (o_access_count),
    .i_list_size      (o_list_size),
    .i_dropped        (o_dropped)
);

@@ tb/tb_count_ordered_search_list.sv @@
// Self-checking testbench for the count ordered search list: directed table, random lookups.
module tb_count_ordered_search_list;
    timeunit 1ns;
    timeprecision 1ps;

    // One result word as the block reports it, field for field at the port widths.
    typedef struct packed {
        logic                        found;
        logic [cosl_pkg::IDX_W-1:0]  position;
        logic [cosl_pkg::CNT_W-1:0]  count;
        logic [cosl_pkg::FILL_W-1:0] size;
        logic [cosl_pkg::SUM_W-1:0]  total;
        logic                        dropped;
    } t_lookup_result;

    // A directed row carries a key and, where the answer is obvious by hand, the typed result.
    typedef struct packed {
        logic [cosl_pkg::KEY_W-1:0] key;
        logic                       typed;
        t_lookup_result             want;
    } t_stim_row;

    localparam int RANDOM_LOOKUPS = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 80;
    localparam int CYCLE_LIMIT    = 2_000_000;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        in_valid     = 1'b0;
    logic [cosl_pkg::KEY_W-1:0]  in_key       = '0;
    logic                        out_stall    = 1'b0;
    logic                        in_stall;
    logic                        out_valid;
    logic                        out_found;
    logic [cosl_pkg::IDX_W-1:0]  out_position;
    logic [cosl_pkg::CNT_W-1:0]  out_count;
    logic [cosl_pkg::FILL_W-1:0] out_size;
    logic [cosl_pkg::SUM_W-1:0]  out_total;
    logic                        out_dropped;

    count_ordered_search_list dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_key            (in_key),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_found          (out_found),
        .o_final_position (out_position),
        .o_access_count   (out_count),
        .o_list_size      (out_size),
        .o_compare_total  (out_total),
        .o_dropped        (out_dropped)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the list. Counts stay non-increasing from front to tail.
    logic [cosl_pkg::KEY_W-1:0] held_keys   [cosl_pkg::DEPTH];
    logic [cosl_pkg::CNT_W-1:0] held_counts [cosl_pkg::DEPTH];
    int                         held        = 0;
    logic [cosl_pkg::SUM_W-1:0] compare_sum = '0;

    t_lookup_result   awaited_lookups [$];
    int               failures    = 0;
    int               cycle_count = 0;

    // Idle rates in percent. The receiver rate is written with nonblocking assignments
    // at the falling edge so the receiver process only sees it at its next falling edge.
    int               in_idle_pct  = 0;
    int               out_idle_pct = 0;

    // The driver asks for a long output hold by bumping this counter; the receiver
    // notices the change and counts the hold down on its own.
    int               hold_asked = 0;
    int               hold_seen  = 0;
    int               hold_left  = 0;

    // Directed rows. The first five start from an empty list and can be worked out by
    // hand: two misses, a hit at the front, a hit that ties with its predecessor and
    // stays put, and a hit that then overtakes it. The rest fill the list to the brim,
    // miss on the full list, and promote the tail entry across the zero-count run.
    t_stim_row directed_rows [23] = '{
        '{8'h00, 1'b1, '{1'b0, 4'd0, 16'd0, 5'd1, 32'd1, 1'b0}},
        '{8'hFF, 1'b1, '{1'b0, 4'd1, 16'd0, 5'd2, 32'd2, 1'b0}},
        '{8'h00, 1'b1, '{1'b1, 4'd0, 16'd1, 5'd2, 32'd3, 1'b0}},
        '{8'hFF, 1'b1, '{1'b1, 4'd1, 16'd1, 5'd2, 32'd5, 1'b0}},
        '{8'hFF, 1'b1, '{1'b1, 4'd0, 16'd2, 5'd2, 32'd7, 1'b0}},
        '{8'h01, 1'b0, '0}, '{8'h02, 1'b0, '0}, '{8'h03, 1'b0, '0},
        '{8'h04, 1'b0, '0}, '{8'h05, 1'b0, '0}, '{8'h06, 1'b0, '0},
        '{8'h07, 1'b0, '0}, '{8'h08, 1'b0, '0}, '{8'h09, 1'b0, '0},
        '{8'h0A, 1'b0, '0}, '{8'h0B, 1'b0, '0}, '{8'h0C, 1'b0, '0},
        '{8'h0D, 1'b0, '0}, '{8'h0E, 1'b0, '0},
        '{8'h55, 1'b0, '0},
        '{8'h0E, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'h0E, 1'b0, '0}
    };

    // Search from the front, bump the count on a hit and let the entry overtake every
    // predecessor with a strictly lower count; on a miss append at the tail, or drop the
    // key when the list is already full. The comparison total grows by the search length.
    function automatic t_lookup_result lookup_and_promote(
        input logic [cosl_pkg::KEY_W-1:0] key);
        t_lookup_result             r;
        int                         p;
        logic [cosl_pkg::CNT_W-1:0] c;
        r = '0;
        p = -1;
        for (int i = 0; i < held; i++) begin
            if (p < 0 && held_keys[i] == key) begin
                p = i;
            end
        end
        if (p >= 0) begin
            compare_sum = compare_sum + cosl_pkg::SUM_W'(p + 1);
            c = held_counts[p];
            if (c != cosl_pkg::CNT_MAX) begin
                c = c + 1'b1;
            end
            while (p > 0 && held_counts[p-1] < c) begin
                held_keys[p]   = held_keys[p-1];
                held_counts[p] = held_counts[p-1];
                p--;
            end
            held_keys[p]   = key;
            held_counts[p] = c;
            r.found    = 1'b1;
            r.position = cosl_pkg::IDX_W'(p);
            r.count    = c;
        end else begin
            compare_sum = compare_sum + cosl_pkg::SUM_W'((held > 0) ? held : 1);
            if (held >= cosl_pkg::DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                held_keys[held]   = key;
                held_counts[held] = '0;
                r.position        = cosl_pkg::IDX_W'(held);
                held              = held + 1;
            end
        end
        r.size  = cosl_pkg::FILL_W'(held);
        r.total = compare_sum;
        return r;
    endfunction

    // Mostly keys that are already held, half of those from the tail half so that
    // entries climb a long way; the rest are random keys that mostly miss and get dropped.
    function automatic logic [cosl_pkg::KEY_W-1:0] pick_key();
        int slot;
        if (held == 0 || $urandom_range(99) < 25) begin
            return cosl_pkg::KEY_W'($urandom_range(2**cosl_pkg::KEY_W - 1));
        end
        if ($urandom_range(1) == 1) begin
            slot = $urandom_range(held - 1, held / 2);
        end else begin
            slot = $urandom_range(held - 1);
        end
        return held_keys[slot];
    endfunction

    // Offer one word, starting at a falling edge, and hold it until the block takes it.
    // The expected result is queued at the accepting edge, so the shadow list is always
    // current when the next key is picked. Returns at the following falling edge.
    task automatic send_key(input logic [cosl_pkg::KEY_W-1:0] key, input logic typed,
                            input t_lookup_result want);
        t_lookup_result predicted;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_key   <= key;
        do begin
            @(posedge i_clk);
        end while (in_stall);
        predicted = lookup_and_promote(key);
        awaited_lookups.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [cosl_pkg::SUM_W-1:0] want,
                                 input logic [cosl_pkg::SUM_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Receiver: random stalls at the current rate, or a long hold when the driver asks.
    always @(negedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left  = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // Every accepted result word is held against the oldest outstanding lookup.
    always @(posedge i_clk) begin : watch_results
        t_lookup_result want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (awaited_lookups.size() == 0) begin
                $error("result word arrived with no lookup outstanding");
                failures++;
            end else begin
                want = awaited_lookups.pop_front();
                compare_field("found", cosl_pkg::SUM_W'(want.found),
                              cosl_pkg::SUM_W'(out_found));
                compare_field("final_position", cosl_pkg::SUM_W'(want.position),
                              cosl_pkg::SUM_W'(out_position));
                compare_field("access_count", cosl_pkg::SUM_W'(want.count),
                              cosl_pkg::SUM_W'(out_count));
                compare_field("list_size", cosl_pkg::SUM_W'(want.size),
                              cosl_pkg::SUM_W'(out_size));
                compare_field("compare_total", want.total, out_total);
                compare_field("dropped", cosl_pkg::SUM_W'(want.dropped),
                              cosl_pkg::SUM_W'(out_dropped));
            end
        end
    end

    // Watchdog: far above the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("count_ordered_search_list verification failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows run with both sides idling lightly.
        in_idle_pct   = 20;
        out_idle_pct <= 20;
        foreach (directed_rows[r]) begin
            send_key(directed_rows[r].key, directed_rows[r].typed, directed_rows[r].want);
        end

        // Sender rarely idles, receiver stalls most of the time.
        in_idle_pct   = 7;
        out_idle_pct <= 72;
        repeat (RANDOM_LOOKUPS / 3) begin
            send_key(pick_key(), 1'b0, '0);
        end

        // The sender goes quiet until the block has answered everything.
        in_valid <= 1'b0;
        while (awaited_lookups.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);

        // Sender idles most of the time, receiver rarely stalls.
        in_idle_pct   = 72;
        out_idle_pct <= 7;
        repeat (RANDOM_LOOKUPS / 3) begin
            send_key(pick_key(), 1'b0, '0);
        end

        // No idling on either side, opening with a long output hold so the block backs
        // up and has to stall its input while words keep being offered.
        in_idle_pct   = 0;
        out_idle_pct <= 0;
        hold_asked   <= hold_asked + 1;
        repeat (RANDOM_LOOKUPS - 2 * (RANDOM_LOOKUPS / 3)) begin
            send_key(pick_key(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (awaited_lookups.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0) begin
            $display("count_ordered_search_list verification clean");
        end else begin
            $display("count_ordered_search_list verification failed");
        end
        $finish;
    end

endmodule
